### hw/rtl/key_debounce_long_press_assert.svh
// Assertion macros shared by the key debounce checkers.
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KDLP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key debounce check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KDLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key debounce check failed");

`endif

### hw/rtl/kdlp_pkg.sv
// Types and constants of the key debouncer with long-press detection.
package kdlp_pkg;

    localparam int KEY_W      = 2;
    localparam int LEVEL_W    = 1;
    localparam int CODE_W     = 2;
    localparam int PATTERN_W  = 8;
    localparam int HELD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Keys that have a pattern register; higher keys use pattern zero.
    localparam int PATTERN_REGS = 3;

    localparam logic [HELD_W-1:0] HELD_MAX         = '1;
    localparam logic [HELD_W-1:0] LONG_TICKS_RESET = HELD_W'(20);

    typedef enum logic [CODE_W-1:0] {
        EVT_RELEASE = 2'd0,
        EVT_PRESS   = 2'd1,
        EVT_LONG    = 2'd2
    } kdlp_evt_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_KEY0 = 2'd0,
        CFG_PATTERN_KEY1 = 2'd1,
        CFG_PATTERN_KEY2 = 2'd2,
        CFG_LONG_TICKS   = 2'd3
    } kdlp_cfg_idx_t;

    typedef struct packed {
        logic [PATTERN_REGS-1:0][PATTERN_W-1:0] pattern;
        logic [HELD_W-1:0]                      long_ticks;
    } kdlp_cfg_t;

    typedef struct packed {
        logic           hit;
        logic [KEY_W-1:0] key;
        kdlp_evt_code_t code;
    } kdlp_evt_t;

endpackage

### hw/rtl/kdlp_if.sv
// Valid/ready channels: scan ticks in, key events out.
interface kdlp_scan_if;
    import kdlp_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   key_index;
    logic [LEVEL_W-1:0] pin_level;

    modport source (output valid, key_index, pin_level, input ready);
    modport sink   (input valid, key_index, pin_level, output ready);
endinterface

interface kdlp_event_if;
    import kdlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  event_key;
    logic [CODE_W-1:0] event_code;

    modport source (output valid, event_key, event_code, input ready);
    modport sink   (input valid, event_key, event_code, output ready);
endinterface

### hw/rtl/kdlp_cfg_regs.sv
// Configuration registers: per-key pressed patterns and long-press threshold.
module kdlp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output kdlp_pkg::kdlp_cfg_t                 cfg
);
    import kdlp_pkg::*;

    kdlp_cfg_t cfg_reg;
    kdlp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_KEY0: cfg_next.pattern[0] = cfg_wdata[PATTERN_W-1:0];
                CFG_PATTERN_KEY1: cfg_next.pattern[1] = cfg_wdata[PATTERN_W-1:0];
                CFG_PATTERN_KEY2: cfg_next.pattern[2] = cfg_wdata[PATTERN_W-1:0];
                CFG_LONG_TICKS:   cfg_next.long_ticks = cfg_wdata[HELD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern    <= '0;
            cfg_reg.long_ticks <= LONG_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/kdlp_key_state.sv
// Per-key debounce state and the read-modify-write that yields at most one event.
module kdlp_key_state #(
    parameter int NUM_KEYS     = 3,
    parameter int HISTORY_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [kdlp_pkg::KEY_W-1:0]      key,
    input  logic [kdlp_pkg::LEVEL_W-1:0]    level,
    input  kdlp_pkg::kdlp_cfg_t             cfg,
    output kdlp_pkg::kdlp_evt_t             evt
);
    import kdlp_pkg::*;

    logic [HISTORY_BITS-1:0] hist_reg        [NUM_KEYS];
    logic [HISTORY_BITS-1:0] hist_next       [NUM_KEYS];
    logic [NUM_KEYS-1:0]     press_armed_reg;
    logic [NUM_KEYS-1:0]     press_armed_next;
    logic [HELD_W-1:0]       held_reg        [NUM_KEYS];
    logic [HELD_W-1:0]       held_next       [NUM_KEYS];
    logic [NUM_KEYS-1:0]     long_armed_reg;
    logic [NUM_KEYS-1:0]     long_armed_next;

    logic                                 key_hit;
    logic [HISTORY_BITS-1:0]              sel_hist;
    logic                                 sel_press_armed;
    logic [HELD_W-1:0]                    sel_held;
    logic                                 sel_long_armed;
    logic [PATTERN_W-1:0]                 sel_pattern;
    logic [PATTERN_W+HISTORY_BITS-1:0]    pat_wide;
    logic [HISTORY_BITS-1:0]              pat;
    logic [HISTORY_BITS-1:0]              hist_new;
    logic                                 is_pat;
    logic                                 is_inv;
    logic                                 held_inc;
    logic [HELD_W-1:0]                    held_upd;
    logic                                 long_fire;
    logic                                 new_press_armed;
    logic                                 new_long_armed;
    logic [HELD_W-1:0]                    new_held;

    // Read port: pick the addressed key's state and pattern.
    always_comb
    begin
        key_hit         = 1'b0;
        sel_hist        = '0;
        sel_press_armed = 1'b0;
        sel_held        = '0;
        sel_long_armed  = 1'b0;
        sel_pattern     = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (int'(key) == k)
            begin
                key_hit         = 1'b1;
                sel_hist        = hist_reg[k];
                sel_press_armed = press_armed_reg[k];
                sel_held        = held_reg[k];
                sel_long_armed  = long_armed_reg[k];
            end
        end
        for (int p = 0; p < PATTERN_REGS; p++)
        begin
            if (int'(key) == p)
            begin
                sel_pattern = cfg.pattern[p];
            end
        end
    end

    assign pat_wide = {{HISTORY_BITS{1'b0}}, sel_pattern};
    assign pat      = pat_wide[HISTORY_BITS-1:0];
    assign hist_new = {sel_hist[HISTORY_BITS-2:0], level};
    assign is_pat   = (hist_new == pat);
    assign is_inv   = (hist_new == ~pat);

    assign held_inc  = is_pat && sel_long_armed && (sel_held != HELD_MAX);
    assign held_upd  = held_inc ? sel_held + HELD_W'(1) : sel_held;
    assign long_fire = held_inc && (held_upd > cfg.long_ticks);

    // Priority: press, then release, then long press.
    always_comb
    begin
        new_press_armed = sel_press_armed;
        new_long_armed  = sel_long_armed;
        new_held        = held_upd;
        evt.hit         = 1'b0;
        evt.key         = key;
        evt.code        = EVT_RELEASE;
        if (is_pat && sel_press_armed)
        begin
            new_press_armed = 1'b0;
            evt.hit         = key_hit;
            evt.code        = EVT_PRESS;
        end
        else if (is_inv && !sel_press_armed)
        begin
            new_press_armed = 1'b1;
            new_held        = '0;
            new_long_armed  = 1'b1;
            evt.hit         = key_hit;
            evt.code        = EVT_RELEASE;
        end
        else if (long_fire)
        begin
            new_long_armed = 1'b0;
            evt.hit        = key_hit;
            evt.code       = EVT_LONG;
        end
    end

    always_comb
    begin
        hist_next        = hist_reg;
        press_armed_next = press_armed_reg;
        held_next        = held_reg;
        long_armed_next  = long_armed_reg;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (step && int'(key) == k)
            begin
                hist_next[k]        = hist_new;
                press_armed_next[k] = new_press_armed;
                held_next[k]        = new_held;
                long_armed_next[k]  = new_long_armed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hist_reg[k] <= '0;
                held_reg[k] <= '0;
            end
            press_armed_reg <= '0;
            long_armed_reg  <= '0;
        end
        else
        begin
            hist_reg        <= hist_next;
            press_armed_reg <= press_armed_next;
            held_reg        <= held_next;
            long_armed_reg  <= long_armed_next;
        end
    end

endmodule

### hw/rtl/key_debounce_long_press.sv
// Key debouncer with press, release and long-press events: top level.
// A scan beat goes into the input register; its event, if any, into the event
// register. Throughput: one scan beat per cycle while events are taken; the
// input and event registers let a new beat enter while an event waits.
// Reset clears all key state and sets the patterns to 0, the threshold to 20.
module key_debounce_long_press #(
    parameter int NUM_KEYS     = 3,
    parameter int HISTORY_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    kdlp_scan_if.sink                       scan,
    kdlp_event_if.source                    events
);
    import kdlp_pkg::*;

    kdlp_cfg_t cfg;
    kdlp_evt_t evt;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [KEY_W-1:0]   in_key_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [KEY_W-1:0]   out_key_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_free;
    logic               proc_fire;
    logic               scan_take;

    kdlp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kdlp_key_state #(
        .NUM_KEYS     (NUM_KEYS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_key_state (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc_fire),
        .key   (in_key_reg),
        .level (in_level_reg),
        .cfg   (cfg),
        .evt   (evt)
    );

    assign out_free   = !out_valid_reg || events.ready;
    assign proc_fire  = in_valid_reg && out_free;
    assign scan.ready = !in_valid_reg || out_free;
    assign scan_take  = scan.valid && scan.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (scan_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire)
        begin
            out_valid_next = evt.hit;
        end
        else if (events.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            in_key_reg   <= scan.key_index;
            in_level_reg <= scan.pin_level;
        end
        if (proc_fire && evt.hit)
        begin
            out_key_reg  <= evt.key;
            out_code_reg <= evt.code;
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.event_key  = out_key_reg;
    assign events.event_code = out_code_reg;

endmodule

### hw/rtl/kdlp_checker.sv
// Port-level checks of the key debouncer, bound to the top level.
`include "key_debounce_long_press_assert.svh"

module kdlp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          scan_valid,
    input logic                          scan_ready,
    input logic                          ev_valid,
    input logic                          ev_ready,
    input logic [kdlp_pkg::KEY_W-1:0]    ev_key,
    input logic [kdlp_pkg::CODE_W-1:0]   ev_code
);
    import kdlp_pkg::*;

    // A stalled event beat holds.
    `KDLP_ASSERT_NEXT(a_ev_hold, ev_valid && !ev_ready, ev_valid && $stable(ev_key) && $stable(ev_code))

    // A fresh event is checked to come from an earlier accepted scan beat.
    `KDLP_ASSERT_IMPL(a_ev_cause, $rose(ev_valid), $past(scan_valid && scan_ready, 2))

    // With no event pending, nothing can block the scan side.
    `KDLP_ASSERT_IMPL(a_scan_open, !ev_valid, scan_ready)

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (scan.valid),
    .scan_ready (scan.ready),
    .ev_valid   (events.valid),
    .ev_ready   (events.ready),
    .ev_key     (events.event_key),
    .ev_code    (events.event_code)
);
